### rtl/core/sap_pkg.sv
// package for the shelf atlas packer: constants, types and opcodes
package sap_pkg;

  localparam int MAX_PAGES_DEF = 8;
  localparam int MAX_SHELVES_DEF = 16;
  localparam int DIM_W = 15;
  localparam int SUM_W = 17;
  localparam int PGOUT_W = 3;
  localparam int PUSED_W = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_PAGE_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_HEIGHT = 1'b1;

  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [DIM_W-1:0] top;
    logic [DIM_W-1:0] height;
    logic [DIM_W-1:0] fill;
  } shelf_t;

endpackage

### rtl/core/sap_cell.sv
// one shelf slot cell of the circular row: holds a shelf and takes its neighbor's on each shift
module sap_cell
  import sap_pkg::*;
(
  input  logic   clk,
  input  logic   shift,
  input  shelf_t din,
  output shelf_t dout
);

  shelf_t shelf;

  always_ff @(posedge clk) begin
    if (shift) begin
      shelf <= din;
    end
  end

  assign dout = shelf;

endmodule

### rtl/core/sap_ctrl.sv
// sequencer: walks the rotating shelf row page by page and forms the result
module sap_ctrl
  import sap_pkg::*;
#(
  parameter int MAX_PAGES = MAX_PAGES_DEF,
  parameter int MAX_SHELVES = MAX_SHELVES_DEF
)
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [DIM_W-1:0]   tile_size,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               placed,
  output logic [PGOUT_W-1:0] page_number,
  output logic [DIM_W-1:0]   pos_x,
  output logic [DIM_W-1:0]   pos_y,
  output logic [PUSED_W-1:0] pages_used,
  input  logic [DIM_W-1:0]   page_width,
  input  logic [DIM_W-1:0]   page_height,
  input  shelf_t             head,
  output shelf_t             wrap,
  output logic               shift
);

  localparam int PG_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int SH_W = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
  localparam int SC_W = $clog2(MAX_SHELVES + 1);
  localparam int PC_W = $clog2(MAX_PAGES + 1);

  // the row rotates one slot a cycle while scanning; pg and sh name the slot at the head
  state_t state, state_next;
  logic [PG_W-1:0] pg;
  logic [SH_W-1:0] sh;
  logic [PC_W-1:0] open_pages;
  logic [SC_W-1:0] shelves [MAX_PAGES];
  logic [DIM_W-1:0] size;
  logic [SUM_W-1:0] bottom;
  logic settled;

  logic [SC_W-1:0] cnt;
  logic [SUM_W-1:0] fit_x, head_bot, new_bot;
  logic scan, live, fresh, fits, take, try_new, append, open_new, settle;
  logic last_sh, last_slot, clear;

  assign cnt = shelves[pg];
  assign fit_x = SUM_W'(head.fill) + SUM_W'(size);
  assign head_bot = SUM_W'(head.top) + SUM_W'(head.height);
  assign new_bot = bottom + SUM_W'(size);
  assign fits = (fit_x <= SUM_W'(page_width)) && (head_bot < SUM_W'(page_height));
  assign scan = (state == ST_SCAN) && !settled;
  assign live = (PC_W'(pg) < open_pages);
  assign fresh = (PC_W'(pg) == open_pages) && (open_pages < PC_W'(MAX_PAGES))
                 && (sh == '0);
  assign take = scan && live && (SC_W'(sh) < cnt) && fits;
  assign try_new = scan && ((live && (SC_W'(sh) == cnt)) || fresh);
  assign append = try_new && (new_bot <= SUM_W'(page_height));
  assign open_new = scan && fresh;
  assign settle = take || append || open_new;
  assign last_sh = (sh == SH_W'(MAX_SHELVES - 1));
  assign last_slot = last_sh && (pg == PG_W'(MAX_PAGES - 1));
  assign clear = (state == ST_IDLE) && in_valid && (op == OP_CLEAR);

  // shelf leaving the head, updated when taken or newly opened
  always_comb begin
    wrap = head;
    if (take) begin
      wrap.fill = head.fill + size;
      if (size > head.height) begin
        wrap.height = size;
      end
    end else if (append) begin
      wrap.top = bottom[DIM_W-1:0];
      wrap.height = size;
      wrap.fill = size;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (op == OP_CLEAR) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_slot) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    out_valid = (state == ST_DONE);
    shift = (state == ST_SCAN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      open_pages <= '0;
      for (int i = 0; i < MAX_PAGES; i++) shelves[i] <= '0;
    end else begin
      state <= state_next;
      if (clear) begin
        open_pages <= '0;
        for (int i = 0; i < MAX_PAGES; i++) shelves[i] <= '0;
      end
      if (append) begin
        shelves[pg] <= cnt + SC_W'(1);
      end
      if (open_new) begin
        open_pages <= open_pages + PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        size <= tile_size;
        pg <= '0;
        sh <= '0;
        bottom <= '0;
        settled <= 1'b0;
        placed <= 1'b0;
        page_number <= '0;
        pos_x <= '0;
        pos_y <= '0;
      end
      ST_SCAN: begin
        sh <= last_sh ? '0 : sh + SH_W'(1);
        if (last_sh) begin
          pg <= pg + PG_W'(1);
          bottom <= '0;
        end else if (live && SC_W'(sh) < cnt) begin
          bottom <= head_bot;
        end
        if (settle) begin
          settled <= 1'b1;
        end
        if (take) begin
          placed <= 1'b1;
          page_number <= PGOUT_W'(pg);
          pos_x <= head.fill;
          pos_y <= head.top;
        end else if (append) begin
          placed <= 1'b1;
          page_number <= PGOUT_W'(pg);
          pos_x <= '0;
          pos_y <= bottom[DIM_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign pages_used = PUSED_W'(open_pages);

endmodule

### rtl/core/shelf_atlas_packer.sv
// top level of the shelf atlas packer: config registers, shelf cell ring and sequencer
// a place beat walks the whole ring once, one slot a cycle: MAX_PAGES*MAX_SHELVES (128) steps
// a place result is valid once the scan has passed every slot of the ring
// one beat at a time; the next beat can be taken in the cycle after the result beat leaves
// a clear result is valid in the cycle after the clear is accepted
// reset clears page and shelf counts and sets both page sizes to 4096; shelf data is not cleared
module shelf_atlas_packer
  import sap_pkg::*;
#(
  parameter int MAX_PAGES = MAX_PAGES_DEF,
  parameter int MAX_SHELVES = MAX_SHELVES_DEF
)
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [DIM_W-1:0]   tile_size,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               placed,
  output logic [PGOUT_W-1:0] page_number,
  output logic [DIM_W-1:0]   pos_x,
  output logic [DIM_W-1:0]   pos_y,
  output logic [PUSED_W-1:0] pages_used,
  input  logic               cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]   cfg_data
);

  localparam int SLOTS = MAX_PAGES * MAX_SHELVES;

  logic [DIM_W-1:0] page_width, page_height;
  logic   shift;
  shelf_t wrap;
  shelf_t shelf [SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      page_width <= DIM_W'(4096);
      page_height <= DIM_W'(4096);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAGE_WIDTH: page_width <= cfg_data;
        REG_PAGE_HEIGHT: page_height <= cfg_data;
        default: ;
      endcase
    end
  end

  sap_ctrl #(
    .MAX_PAGES(MAX_PAGES),
    .MAX_SHELVES(MAX_SHELVES)
  ) u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .op, .tile_size,
    .out_valid, .out_ready, .placed, .page_number, .pos_x, .pos_y, .pages_used,
    .page_width, .page_height,
    .head(shelf[0]), .wrap, .shift
  );

  // cell 0 is the head; the updated head shelf re-enters at the far end
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS - 1) begin : g_tail
      sap_cell u_cell (
        .clk, .shift,
        .din(wrap),
        .dout(shelf[i])
      );
    end else begin : g_body
      sap_cell u_cell (
        .clk, .shift,
        .din(shelf[i+1]),
        .dout(shelf[i])
      );
    end
  end

endmodule
